>>> rtl/sfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, codes and helpers for the serial frame checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int MAX_LEN_DEF = 64;

  // Fixed field widths
  localparam int STATUS_W     = 3;
  localparam int BYTE_INDEX_W = 6;
  localparam int FRAME_LEN_W  = 7;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_STX_MODE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STX_CHAR        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ETX_CHAR        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECKSUM_ENABLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHECKSUM_TYPE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NAK_ENABLE      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_NAK_CHAR        = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN         = 3'd7;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_SHORT     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_SUM   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_STRAY_EOL = 3'd4;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_EMIT
  } sfc_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [7:0]              data_byte;
    logic [BYTE_INDEX_W-1:0] byte_index;
    logic [FRAME_LEN_W-1:0]  frame_length;
    logic                    body_present;
    logic                    last;
    logic                    send_nak;
    logic [7:0]              nak_byte;
  } sfc_result_t;

  // Checksum byte expected after the given sum of the preceding body bytes.
  // Type 0: negated sum, low seven bits, with 0x40 forced on.
  // Type 1: low seven bits plus 33, folded back into 33..126.
  function automatic logic [7:0] sfc_expected_check(input logic [7:0] sum,
                                                     input logic       ctype);
    logic [7:0] neg;
    logic [7:0] c;
    begin
      neg = 8'h00 - sum;
      if (!ctype) begin
        c = (neg & 8'h7F) | 8'h40;
      end else begin
        c = {1'b0, sum[6:0]} + 8'd33;
        if (c > 8'd126) begin
          c = c - 8'd94;
        end
      end
      return c;
    end
  endfunction

endpackage

>>> rtl/sfc_body_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_body_mem
// Frame body store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfc_body_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/serial_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_checker
// Byte-serial frame receiver with start/end framing and checksum check.
// ----------------------------------------------------------------------------
// Each received byte is taken in the idle state and then, in the evaluate state,
// checked against the frame state and written into the body memory; the
// evaluation cycle waits while an earlier result is still held in the output
// register. On a valid end byte the stored body is read back from the
// single-port-read body memory one body byte at a time (read, then load
// into the output register), so new input is held off until the whole body
// has been drained, output stalls included. Rejected frames and a stray
// newline while idle give one error result. No clearing pass is needed after
// reset.
module serial_frame_checker #(
  parameter int MAX_LEN = sfc_pkg::MAX_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [sfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // received bytes
  input  logic                                byte_valid,
  output logic                                byte_ready,
  input  logic [7:0]                          rx_byte,
  // results
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [sfc_pkg::STATUS_W-1:0]        status,
  output logic [7:0]                          data_byte,
  output logic [sfc_pkg::BYTE_INDEX_W-1:0]    byte_index,
  output logic [sfc_pkg::FRAME_LEN_W-1:0]     frame_length,
  output logic                                body_present,
  output logic                                last,
  output logic                                send_nak,
  output logic [7:0]                          nak_byte
);

  import sfc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  // configuration
  logic [1:0] stx_mode;
  logic [7:0] stx_char;
  logic [7:0] etx_char;
  logic       checksum_enable;
  logic       checksum_type;
  logic       nak_enable;
  logic [7:0] nak_char;
  logic [6:0] min_len;

  // frame state
  sfc_state_t       state, state_next;
  logic [7:0]       rx_hold;
  logic [CNT_W-1:0] wr_idx, wr_idx_next;
  logic [7:0]       run_sum, run_sum_next;
  logic [7:0]       last_stored, last_stored_next;
  logic             in_frame, in_frame_next;
  logic [CNT_W-1:0] rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] frame_len, frame_len_next;

  // output register
  sfc_result_t result, result_next;
  logic        out_load;
  logic        out_free;

  // memory port
  logic       body_we;
  logic       body_re;
  logic [7:0] body_rdata;

  logic [7:0] sum_before;
  logic       sum_ok;

  assign out_free   = !result_valid || result_ready;
  assign byte_ready = (state == ST_IDLE);
  assign sum_before = run_sum - last_stored;
  assign sum_ok     = (last_stored == sfc_expected_check(sum_before, checksum_type));

  sfc_body_mem #(
    .DEPTH  (MAX_LEN),
    .ADDR_W (ADDR_W)
  ) u_body_mem (
    .clk   (clk),
    .we    (body_we),
    .waddr (wr_idx[ADDR_W-1:0]),
    .wdata (rx_hold),
    .re    (body_re),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (body_rdata)
  );

  always_comb begin
    state_next       = state;
    wr_idx_next      = wr_idx;
    run_sum_next     = run_sum;
    last_stored_next = last_stored;
    in_frame_next    = in_frame;
    rd_ptr_next      = rd_ptr;
    frame_len_next   = frame_len;
    body_we          = 1'b0;
    body_re          = 1'b0;
    out_load         = 1'b0;
    result_next              = '0;
    result_next.last         = 1'b1;
    result_next.send_nak     = nak_enable;
    result_next.nak_byte     = nak_char;

    case (state)
      ST_IDLE: begin
        if (byte_valid) begin
          state_next = ST_EVAL;
        end
      end

      ST_EVAL: begin
        // hold off until the output register can take a result
        if (out_free) begin
          state_next = ST_IDLE;
          if (!in_frame) begin
            if (rx_hold == stx_char) begin
              in_frame_next = 1'b1;
            end else if (rx_hold == NEWLINE_CHAR) begin
              out_load           = 1'b1;
              result_next.status = STAT_STRAY_EOL;
            end
          end else if (stx_mode != 2'd0 && rx_hold == stx_char) begin
            wr_idx_next      = '0;
            run_sum_next     = '0;
            last_stored_next = '0;
          end else if (rx_hold != etx_char) begin
            if (wr_idx < MAX_CNT) begin
              body_we          = 1'b1;
              wr_idx_next      = wr_idx + 1'b1;
              run_sum_next     = run_sum + rx_hold;
              last_stored_next = rx_hold;
            end else begin
              wr_idx_next        = '0;
              run_sum_next       = '0;
              last_stored_next   = '0;
              out_load           = 1'b1;
              result_next.status = STAT_OVERFLOW;
            end
          end else begin
            // end byte: every path empties the body
            wr_idx_next      = '0;
            run_sum_next     = '0;
            last_stored_next = '0;
            if (7'(wr_idx) < min_len) begin
              out_load           = 1'b1;
              result_next.status = STAT_SHORT;
            end else if (checksum_enable && (wr_idx == '0 || !sum_ok)) begin
              out_load           = 1'b1;
              result_next.status = STAT_BAD_SUM;
            end else begin
              if (stx_mode[1]) begin
                in_frame_next = 1'b0;
              end
              frame_len_next = checksum_enable ? wr_idx - 1'b1 : wr_idx;
              if (frame_len_next == '0) begin
                out_load             = 1'b1;
                result_next.status   = STAT_OK;
                result_next.send_nak = 1'b0;
              end else begin
                rd_ptr_next = '0;
                state_next  = ST_READ;
              end
            end
          end
        end
      end

      ST_READ: begin
        body_re    = 1'b1;
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        result_next.status       = STAT_OK;
        result_next.data_byte    = body_rdata;
        result_next.byte_index   = BYTE_INDEX_W'(rd_ptr);
        result_next.frame_length = FRAME_LEN_W'(frame_len);
        result_next.body_present = 1'b1;
        result_next.last         = (rd_ptr + 1'b1 == frame_len);
        result_next.send_nak     = 1'b0;
        if (out_free) begin
          out_load    = 1'b1;
          rd_ptr_next = rd_ptr + 1'b1;
          state_next  = result_next.last ? ST_IDLE : ST_READ;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wr_idx      <= '0;
      run_sum     <= '0;
      last_stored <= '0;
      rd_ptr      <= '0;
      frame_len   <= '0;
    end else begin
      state       <= state_next;
      wr_idx      <= wr_idx_next;
      run_sum     <= run_sum_next;
      last_stored <= last_stored_next;
      rd_ptr      <= rd_ptr_next;
      frame_len   <= frame_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      rx_hold <= rx_byte;
    end
  end

  // configuration registers; a stx_mode write of 2 or 3 leaves the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      stx_mode        <= 2'd0;
      stx_char        <= 8'd36;
      etx_char        <= 8'd10;
      checksum_enable <= 1'b0;
      checksum_type   <= 1'b0;
      nak_enable      <= 1'b0;
      nak_char        <= 8'd78;
      min_len         <= 7'd2;
      in_frame        <= 1'b1;
    end else begin
      if (cfg_we && cfg_index == CFG_STX_MODE && cfg_data[1]) begin
        in_frame <= 1'b0;
      end else begin
        in_frame <= in_frame_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_STX_MODE:        stx_mode        <= cfg_data[1:0];
          CFG_STX_CHAR:        stx_char        <= cfg_data;
          CFG_ETX_CHAR:        etx_char        <= cfg_data;
          CFG_CHECKSUM_ENABLE: checksum_enable <= cfg_data[0];
          CFG_CHECKSUM_TYPE:   checksum_type   <= cfg_data[0];
          CFG_NAK_ENABLE:      nak_enable      <= cfg_data[0];
          CFG_NAK_CHAR:        nak_char        <= cfg_data;
          CFG_MIN_LEN:         min_len         <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= result_next;
    end
  end

  assign status       = result.status;
  assign data_byte    = result.data_byte;
  assign byte_index   = result.byte_index;
  assign frame_length = result.frame_length;
  assign body_present = result.body_present;
  assign last         = result.last;
  assign send_nak     = result.send_nak;
  assign nak_byte     = result.nak_byte;

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!result_valid || result_ready))
    else $error("result register overwritten");

  // body writes stay inside the store
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    body_we |-> (wr_idx < MAX_CNT))
    else $error("body write past end of store");

  // a memory read is always followed by the emit step that uses it
  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_EMIT))
    else $error("read data not consumed");

  // drained body bytes stay below the frame length
  a_drain_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (rd_ptr < frame_len))
    else $error("drain pointer past frame length");

  // a body byte result carries an index inside its frame
  a_body_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && body_present) |-> (7'(byte_index) < frame_length))
    else $error("body byte index outside frame");

endmodule

>>> bench/serial_frame_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_checker_tb
// Self-checking bench for the serial frame checker: a short table of framing
// corner cases, then random framed traffic under several register settings
// with random stalls on both channels, checked against a behavioral model.
// ----------------------------------------------------------------------------
module serial_frame_checker_tb;
  import sfc_pkg::*;

  localparam int BODY_MAX      = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BYTES   = 25;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   byte_valid = 1'b0;
  logic                   byte_ready;
  logic [7:0]             rx_byte = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [7:0]             data_byte;
  logic [BYTE_INDEX_W-1:0] byte_index;
  logic [FRAME_LEN_W-1:0] frame_length;
  logic                   body_present;
  logic                   last;
  logic                   send_nak;
  logic [7:0]             nak_byte;

  serial_frame_checker #(.MAX_LEN(BODY_MAX)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .byte_valid(byte_valid), .byte_ready(byte_ready), .rx_byte(rx_byte),
    .result_valid(result_valid), .result_ready(result_ready),
    .status(status), .data_byte(data_byte), .byte_index(byte_index),
    .frame_length(frame_length), .body_present(body_present), .last(last),
    .send_nak(send_nak), .nak_byte(nak_byte)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef enum bit {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [7:0]             val;
    bit                     typed;
    sfc_result_t            res;
  } dir_row_t;

  localparam sfc_result_t NO_RES = '0;
  localparam sfc_result_t SHORT_AT_RESET =
    '{STAT_SHORT, 8'h00, 6'd0, 7'd0, 1'b0, 1'b1, 1'b0, 8'h4E};
  localparam sfc_result_t EMPTY_FRAME_OK =
    '{STAT_OK, 8'h00, 6'd0, 7'd0, 1'b0, 1'b1, 1'b0, 8'hFF};
  localparam sfc_result_t BAD_SUM_NAK =
    '{STAT_BAD_SUM, 8'h00, 6'd0, 7'd0, 1'b0, 1'b1, 1'b1, 8'hFF};
  localparam sfc_result_t STRAY_EOL_NAK =
    '{STAT_STRAY_EOL, 8'h00, 6'd0, 7'd0, 1'b0, 1'b1, 1'b1, 8'hFF};

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_BYTE, '0, 8'h0A, 1'b1, SHORT_AT_RESET},   // end byte, nothing stored
    '{ROW_BYTE, '0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'hFF, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h0A, 1'b0, NO_RES},
    '{ROW_REG, CFG_NAK_ENABLE, 8'h01, 1'b0, NO_RES},
    '{ROW_REG, CFG_NAK_CHAR, 8'hFF, 1'b0, NO_RES},
    '{ROW_REG, CFG_MIN_LEN, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h0A, 1'b1, EMPTY_FRAME_OK},   // empty frame is valid
    '{ROW_REG, CFG_CHECKSUM_ENABLE, 8'h01, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h0A, 1'b1, BAD_SUM_NAK},      // empty with checksum on
    '{ROW_BYTE, '0, 8'h41, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h7F, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h0A, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h41, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h00, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h0A, 1'b1, BAD_SUM_NAK},
    '{ROW_REG, CFG_CHECKSUM_TYPE, 8'h01, 1'b0, NO_RES},
    '{ROW_REG, CFG_STX_CHAR, 8'h02, 1'b0, NO_RES},
    '{ROW_REG, CFG_STX_MODE, 8'h02, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h55, 1'b0, NO_RES},           // idle, dropped
    '{ROW_BYTE, '0, 8'h0A, 1'b1, STRAY_EOL_NAK},
    '{ROW_BYTE, '0, 8'h02, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h41, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h02, 1'b0, NO_RES},           // restart empties body
    '{ROW_BYTE, '0, 8'h30, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h51, 1'b0, NO_RES},
    '{ROW_BYTE, '0, 8'h0A, 1'b0, NO_RES}
  };

  // --------------------------------------------------------------------------
  // Frame model: shadow registers and receive state
  // --------------------------------------------------------------------------
  logic [1:0] r_stx_mode;
  logic [7:0] r_stx_char, r_etx_char, r_nak_char;
  logic       r_cks_en, r_cks_type, r_nak_en;
  logic [6:0] r_min_len;

  logic [7:0] fr_body [BODY_MAX];
  logic [6:0] fr_count;
  logic [7:0] fr_sum;
  logic [7:0] fr_last;
  logic       fr_open;

  sfc_result_t step_results[$];
  sfc_result_t pending_results[$];

  // tag carried alongside a table byte whose result is typed in
  logic        row_checked = 1'b0;
  sfc_result_t row_result = '0;

  int mismatch_count = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int settings_applied = 0;
  int status_tally [8];
  int cycle_count = 0;

  function automatic logic [7:0] check_byte_for(input logic [7:0] sum,
                                                 input logic ctype);
    logic [7:0] neg;
    logic [7:0] v;
    neg = 8'd0 - sum;
    if (!ctype) begin
      v = {2'b01, neg[5:0]};
    end else begin
      v = {1'b0, sum[6:0]} + 8'd33;
      if (v > 8'd126) v = v - 8'd94;
    end
    return v;
  endfunction

  function automatic sfc_result_t err_result(input logic [STATUS_W-1:0] st);
    sfc_result_t r;
    r = '0;
    r.status   = st;
    r.last     = 1'b1;
    r.send_nak = r_nak_en;
    r.nak_byte = r_nak_char;
    return r;
  endfunction

  task automatic clear_frame();
    fr_count = '0;
    fr_sum   = '0;
    fr_last  = '0;
  endtask

  // work out the results caused by one received byte
  task automatic rx_predict(input logic [7:0] b);
    logic [6:0]  body_len;
    sfc_result_t r;
    int          k;
    step_results.delete();
    if (!fr_open) begin
      if (b == r_stx_char) fr_open = 1'b1;
      else if (b == NEWLINE_CHAR) step_results.push_back(err_result(STAT_STRAY_EOL));
    end else if (r_stx_mode != 2'd0 && b == r_stx_char) begin
      clear_frame();
    end else if (b != r_etx_char) begin
      if (fr_count < BODY_MAX) begin
        fr_body[fr_count[5:0]] = b;
        fr_count = fr_count + 7'd1;
        fr_sum   = fr_sum + b;
        fr_last  = b;
      end else begin
        clear_frame();
        step_results.push_back(err_result(STAT_OVERFLOW));
      end
    end else if (fr_count < r_min_len) begin
      clear_frame();
      step_results.push_back(err_result(STAT_SHORT));
    end else if (r_cks_en &&
                 (fr_count == 7'd0 ||
                  fr_last != check_byte_for(fr_sum - fr_last, r_cks_type))) begin
      clear_frame();
      step_results.push_back(err_result(STAT_BAD_SUM));
    end else begin
      body_len = r_cks_en ? fr_count - 7'd1 : fr_count;
      if (body_len == 7'd0) begin
        r = '0;
        r.status   = STAT_OK;
        r.last     = 1'b1;
        r.nak_byte = r_nak_char;
        step_results.push_back(r);
      end else begin
        for (k = 0; k < int'(body_len); k++) begin
          r = '0;
          r.status       = STAT_OK;
          r.data_byte    = fr_body[k];
          r.byte_index   = 6'(k);
          r.frame_length = body_len;
          r.body_present = 1'b1;
          r.last         = (k + 1 == int'(body_len));
          r.nak_byte     = r_nak_char;
          step_results.push_back(r);
        end
      end
      clear_frame();
      if (r_stx_mode[1]) fr_open = 1'b0;
    end
  endtask

  function automatic string fmt_res(input sfc_result_t r);
    return $sformatf("st=%0d data=%02h idx=%0d len=%0d body=%0b last=%0b nak=%0b/%02h",
                     r.status, r.data_byte, r.byte_index, r.frame_length,
                     r.body_present, r.last, r.send_nak, r.nak_byte);
  endfunction

  task automatic note_fail(input string what, input sfc_result_t e,
                           input sfc_result_t g);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected %s, got %s", $time, what, fmt_res(e), fmt_res(g));
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: compare results, shadow register writes, predict on input
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    sfc_result_t got;
    if (rst) begin
      r_stx_mode = 2'd0;
      r_stx_char = 8'd36;
      r_etx_char = 8'd10;
      r_cks_en   = 1'b0;
      r_cks_type = 1'b0;
      r_nak_en   = 1'b0;
      r_nak_char = 8'd78;
      r_min_len  = 7'd2;
      clear_frame();
      fr_open = 1'b1;
      pending_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        got = '{status, data_byte, byte_index, frame_length, body_present, last,
                send_nak, nak_byte};
        results_checked++;
        status_tally[got.status]++;
        if (pending_results.size() == 0) note_fail("unexpected result", '0, got);
        else if (got !== pending_results[0])
          note_fail("result mismatch", pending_results.pop_front(), got);
        else void'(pending_results.pop_front());
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_STX_MODE: begin
            r_stx_mode = cfg_data[1:0];
            if (cfg_data[1]) fr_open = 1'b0;
          end
          CFG_STX_CHAR:        r_stx_char = cfg_data;
          CFG_ETX_CHAR:        r_etx_char = cfg_data;
          CFG_CHECKSUM_ENABLE: r_cks_en   = cfg_data[0];
          CFG_CHECKSUM_TYPE:   r_cks_type = cfg_data[0];
          CFG_NAK_ENABLE:      r_nak_en   = cfg_data[0];
          CFG_NAK_CHAR:        r_nak_char = cfg_data;
          CFG_MIN_LEN:         r_min_len  = cfg_data[6:0];
          default: ;
        endcase
      end
      if (byte_valid && byte_ready) begin
        rx_predict(rx_byte);
        if (row_checked) pending_results.push_back(row_result);
        else foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random per-transaction stalls plus one long hold-off
  // --------------------------------------------------------------------------
  logic hold_req = 1'b0;
  logic hold_off = 1'b0;
  logic rcv_burst = 1'b0;
  int   ready_wait = 0;

  function automatic int draw_wait(input logic burst);
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : result_side
    int w;
    if (rst) begin
      result_ready <= 1'b0;
      ready_wait   <= 0;
    end else if (hold_off) begin
      result_ready <= 1'b0;
    end else if (result_ready) begin
      if (result_valid) begin
        w = draw_wait(rcv_burst);
        if ($urandom_range(0, 24) == 0) rcv_burst <= ~rcv_burst;
        if (w != 0) begin
          result_ready <= 1'b0;
          ready_wait   <= w;
        end
      end
    end else if (ready_wait == 0) begin
      result_ready <= 1'b1;
    end else if (result_valid) begin
      ready_wait <= ready_wait - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte side
  // --------------------------------------------------------------------------
  logic       tx_burst = 1'b0;
  logic       tx_rush = 1'b0;
  logic [1:0] cur_mode;
  logic [7:0] cur_stx, cur_etx;
  logic       cur_cks, cur_type;

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input sfc_result_t res = '0);
    int gap;
    gap = (tx_burst || tx_rush) ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 29) == 0) tx_burst = ~tx_burst;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid  <= 1'b1;
    rx_byte     <= b;
    row_checked <= typed;
    row_result  <= res;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // drop valid, wait for every expected result, then let the block go quiet
  task automatic settle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [1:0] mode, input logic [7:0] stx,
                               input logic [7:0] etx, input logic cks,
                               input logic ctype, input logic naken,
                               input logic [7:0] nak, input logic [6:0] minl);
    logic open_now;
    settle();
    open_now = fr_open && !mode[1];
    cfg_write(CFG_STX_MODE, {6'd0, mode});
    cfg_write(CFG_STX_CHAR, stx);
    cfg_write(CFG_ETX_CHAR, etx);
    cfg_write(CFG_CHECKSUM_ENABLE, {7'd0, cks});
    cfg_write(CFG_CHECKSUM_TYPE, {7'd0, ctype});
    cfg_write(CFG_NAK_ENABLE, {7'd0, naken});
    cfg_write(CFG_NAK_CHAR, nak);
    cfg_write(CFG_MIN_LEN, {1'b0, minl});
    cfg_we <= 1'b0;
    cur_mode = mode;
    cur_stx  = stx;
    cur_etx  = etx;
    cur_cks  = cks;
    cur_type = ctype;
    settings_applied++;
    // no start byte in this mode, so open the frame once by hand
    if (mode == 2'd0 && !open_now) send_byte(stx);
  endtask

  task automatic send_frame(input int len, input bit with_start, input bit spoil);
    logic [7:0] b, sum, chk;
    int k;
    sum = '0;
    if (with_start) send_byte(cur_stx);
    for (k = 0; k < len; k++) begin
      b = 8'($urandom);
      while (b == cur_etx || (cur_mode != 2'd0 && b == cur_stx)) b = 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    if (cur_cks) begin
      chk = check_byte_for(sum, cur_type);
      if (spoil) chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(chk);
    end
    send_byte(cur_etx);
  endtask

  initial begin
    logic prev_reg;
    int   ph, pick, len, target, k;
    logic [6:0] minl;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    prev_reg = 1'b0;
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_REG) begin
        if (!prev_reg) settle();
        cfg_write(DIR_TAB[i].idx, DIR_TAB[i].val);
        prev_reg = 1'b1;
      end else begin
        if (prev_reg) cfg_we <= 1'b0;
        send_byte(DIR_TAB[i].val, DIR_TAB[i].typed, DIR_TAB[i].res);
        prev_reg = 1'b0;
      end
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(0, 99);
      minl = (pick < 70) ? 7'($urandom_range(0, 4)) :
             (pick < 90) ? 7'($urandom_range(0, 64)) : 7'd64;
      case (ph)
        0: apply_setting(2'd2, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00, 7'd0);
        1: apply_setting(2'd1, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF, 7'd1);
        default:
          apply_setting(2'($urandom_range(0, 2)),
                        $urandom_range(0, 1) ? 8'h24 : 8'($urandom),
                        $urandom_range(0, 1) ? 8'h0A : 8'($urandom),
                        1'($urandom), 1'($urandom), 1'($urandom),
                        8'($urandom), minl);
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          // framed traffic, now and then with a spoiled checksum; mostly short bodies, a few near the size limit
          k = $urandom_range(0, 99);
          len = (k < 85) ? $urandom_range(0, 6) :
                (k < 95) ? $urandom_range(7, 20) : $urandom_range(60, 66);
          send_frame(len, cur_mode == 2'd2 || $urandom_range(0, 3) != 0,
                     $urandom_range(0, 9) == 0);
        end else if (pick < 85) begin
          // frame cut off without an end byte
          send_byte(cur_stx);
          len = $urandom_range(1, 5);
          for (k = 0; k < len; k++) send_byte(8'($urandom));
        end else if (pick < 93) begin
          send_byte($urandom_range(0, 1) ? NEWLINE_CHAR : cur_etx);
        end else begin
          len = $urandom_range(1, 4);
          for (k = 0; k < len; k++) send_byte(8'($urandom));
        end
      end
    end

    // full-size bodies, with the result side held off while bytes keep coming
    apply_setting(2'd1, 8'h24, 8'h0A, 1'b0, 1'b0, 1'b1, 8'h15, 7'd64);
    tx_rush  = 1'b1;
    hold_req = 1'b1;
    send_frame(64, 1'b1, 1'b0);
    send_frame(63, 1'b1, 1'b0);
    send_frame(66, 1'b1, 1'b0);
    tx_rush = 1'b0;
    apply_setting(2'd2, 8'h24, 8'h0A, 1'b1, 1'b1, 1'b0, 8'h15, 7'd64);
    send_frame(63, 1'b1, 1'b0);
    settle();

    $display("Covered %0d received bytes over %0d register settings, %0d results checked",
             bytes_sent, settings_applied, results_checked);
    $display("Status mix: ok %0d, short %0d, bad checksum %0d, overflow %0d, stray newline %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
